// ----- hw/rtl/tga_pkg.sv -----
// tga_pkg: shared types and constants for the tga pixel stream decoder
// no dependencies

package tga_pkg;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP   = 3'd1,
      PH_RAW    = 3'd2,
      PH_PACKET = 3'd3,
      PH_RLEPIX = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [4:0] HDR_DEPTH_IDX = 5'd16;

   // one decoded result, as it travels from the parser to the output queue
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [2:0]  channels;
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } result_type;

endpackage

// ----- hw/rtl/tga_parser.sv -----
// tga_parser: front part, byte-wise header parse and pixel decode
// depends on tga_pkg

module tga_parser import tga_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] rle_type_code,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   input  logic       frame_start,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  hcount_ff, hcount_in;
   logic [8:0]  skip_ff, skip_in;
   logic        is_rle_ff, is_rle_in;
   logic [7:0]  depth_ff, depth_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic        run_ff, run_in;
   logic [1:0]  cidx_ff, cidx_in;
   logic [7:0]  cb_ff [4];

   phase_type   ph;
   logic [4:0]  hc;
   logic        fmt_ok;
   logic        is32;
   logic [7:0]  b0, b1, b2, b3;
   logic [15:0] w16;
   logic [7:0]  rep;
   logic [31:0] area;
   logic [1:0]  need_m1;
   logic        cb_we;

   assign area = 32'(width_ff) * 32'(height_ff);

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      skip_in   = skip_ff;
      is_rle_in = is_rle_ff;
      depth_in  = depth_ff;
      width_in  = width_ff;
      height_in = height_ff;
      left_in   = left_ff;
      pkt_in    = pkt_ff;
      run_in    = run_ff;
      cidx_in   = cidx_ff;
      res_valid = 1'b0;
      res       = '0;
      res.width = width_ff;
      res.height = height_ff;
      cb_we     = 1'b0;
      fmt_ok    = 1'b0;
      rep       = 8'd1;
      w16       = '0;
      ph = frame_start ? PH_HEADER : phase_ff;
      hc = frame_start ? 5'd0 : hcount_ff;
      is32 = (depth_ff == DEPTH_32);
      // current byte overrides the stored color byte at its slot
      b0 = (cidx_ff == 2'd0) ? data_byte : cb_ff[0];
      b1 = (cidx_ff == 2'd1) ? data_byte : cb_ff[1];
      b2 = (cidx_ff == 2'd2) ? data_byte : cb_ff[2];
      b3 = (cidx_ff == 2'd3) ? data_byte : cb_ff[3];
      need_m1 = (depth_ff == DEPTH_16) ? 2'd1 : (is32 ? 2'd3 : 2'd2);
      if (byte_valid) begin
         phase_in = ph;
         hcount_in = hc;
         case (ph)
            PH_HEADER: begin
               if (hc == 5'd0) skip_in = 9'(data_byte) + 9'd1;
               if (hc == 5'd2) is_rle_in = (data_byte == rle_type_code);
               if (hc == 5'd12) width_in[7:0] = data_byte;
               if (hc == 5'd13) width_in[15:8] = data_byte;
               if (hc == 5'd14) height_in[7:0] = data_byte;
               if (hc == 5'd15) height_in[15:8] = data_byte;
               if (hc < HDR_DEPTH_IDX) begin
                  hcount_in = hc + 5'd1;
               end else begin
                  depth_in = data_byte;
                  fmt_ok = (data_byte == DEPTH_24) || (data_byte == DEPTH_32) ||
                           (!is_rle_ff && data_byte == DEPTH_16);
                  res_valid = 1'b1;
                  if (!fmt_ok) begin
                     res.kind = KIND_ERROR;
                     res.last = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     left_in = area;
                     res.kind = KIND_HEADER;
                     res.channels = (data_byte == DEPTH_32) ? 3'd4 : 3'd3;
                     if (area == 32'd0) begin
                        res.last = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (skip_ff != 9'd0) skip_in = skip_ff - 9'd1;
               if (skip_ff <= 9'd1) begin
                  phase_in = is_rle_ff ? PH_PACKET : PH_RAW;
                  cidx_in = 2'd0;
               end
            end
            PH_RAW, PH_RLEPIX: begin
               cb_we = 1'b1;
               if (cidx_ff < need_m1) begin
                  cidx_in = cidx_ff + 2'd1;
               end else begin
                  cidx_in = 2'd0;
                  res_valid = 1'b1;
                  res.kind = KIND_PIXEL;
                  if (ph == PH_RLEPIX) begin
                     if (run_ff) begin
                        rep = (32'(pkt_ff) > left_ff) ? left_ff[7:0] : pkt_ff;
                        pkt_in = 8'd0;
                     end else begin
                        pkt_in = pkt_ff - 8'd1;
                     end
                  end
                  if (depth_ff == DEPTH_16) begin
                     w16 = {b1, b0};
                     res.red = {w16[14:10], 3'b000};
                     res.green = {w16[9:5], 3'b000};
                     res.blue = {w16[4:0], 3'b000};
                     res.channels = 3'd3;
                  end else begin
                     res.red = b2;
                     res.green = b1;
                     res.blue = b0;
                     res.alpha = is32 ? b3 : 8'd0;
                     res.channels = is32 ? 3'd4 : 3'd3;
                  end
                  res.repeat_res = rep;
                  left_in = left_ff - 32'(rep);
                  if (left_in == 32'd0) begin
                     res.last = 1'b1;
                     phase_in = PH_DONE;
                  end else if (ph == PH_RLEPIX && pkt_in == 8'd0) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
            PH_PACKET: begin
               if (!data_byte[7]) begin
                  pkt_in = data_byte + 8'd1;
                  run_in = 1'b0;
               end else begin
                  pkt_in = data_byte - 8'd127;
                  run_in = 1'b1;
               end
               cidx_in = 2'd0;
               phase_in = PH_RLEPIX;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcount_ff <= '0;
         skip_ff   <= '0;
         is_rle_ff <= 1'b0;
         depth_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         left_ff   <= '0;
         pkt_ff    <= '0;
         run_ff    <= 1'b0;
         cidx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         skip_ff   <= skip_in;
         is_rle_ff <= is_rle_in;
         depth_ff  <= depth_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         left_ff   <= left_in;
         pkt_ff    <= pkt_in;
         run_ff    <= run_in;
         cidx_ff   <= cidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cb_we) cb_ff[cidx_ff] <= data_byte;
   end

   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_ERROR |-> res.last)
      else $error("error result without last");
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PIXEL |-> res.repeat_res != 8'd0)
      else $error("pixel with zero repeat");
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last |=> phase_ff == PH_DONE)
      else $error("last result did not end the image");

endmodule

// ----- hw/rtl/tga_queue.sv -----
// tga_queue: back part, two-entry result queue toward the output channel
// depends on tga_pkg

module tga_queue import tga_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       not_full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   result_type mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign pop = out_valid && !out_stall;
   assign not_full = (count_ff != 2'd2);
   assign out_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> count_ff != 2'd2)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid)
      else $error("stalled result dropped");
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count overflow");

endmodule

// ----- hw/rtl/tga_pixel_stream_decoder_unit.sv -----
// tga_pixel_stream_decoder_unit: top level of the tga byte stream decoder
// depends on tga_pkg, tga_parser, tga_queue

// Takes one TGA file byte per cycle and gives at most one result per byte:
// a header result after the bit depth byte, one result per pixel or run, or
// an error result for unsupported formats. The parser forms its next state
// and result combinationally from each byte, so a byte is taken every cycle
// while the two-entry result queue has room; req_stall rises whenever that
// queue is full, also in a cycle in which the output side takes a result.
module tga_pixel_stream_decoder_unit import tga_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_res,
   output logic [2:0]  rsp_channels,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic        rsp_last
);

   logic [7:0] rle_code_ff;
   logic       not_full;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type q_out;

   assign req_stall = !not_full;
   assign accept = req_valid && not_full;

   always_ff @(posedge clock) begin
      if (reset) rle_code_ff <= 8'd10;
      else if (csr_we) rle_code_ff <= csr_wdata;
   end

   tga_parser u_parser (
      .clock, .reset,
      .rle_type_code(rle_code_ff),
      .byte_valid(accept),
      .data_byte(req_data_byte),
      .frame_start(req_frame_start),
      .res_valid, .res
   );

   tga_queue u_queue (
      .clock, .reset,
      .push(res_valid),
      .push_data(res),
      .not_full,
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data(q_out)
   );

   assign rsp_result_kind = q_out.kind;
   assign rsp_red = q_out.red;
   assign rsp_green = q_out.green;
   assign rsp_blue = q_out.blue;
   assign rsp_alpha = q_out.alpha;
   assign rsp_repeat_res = q_out.repeat_res;
   assign rsp_channels = q_out.channels;
   assign rsp_width = q_out.width;
   assign rsp_height = q_out.height;
   assign rsp_last = q_out.last;

endmodule

// ----- verif/tb_tga_pixel_stream_decoder_unit.sv -----
// tb_tga_pixel_stream_decoder_unit: self-checking testbench for the tga byte stream decoder
// builds tga files byte by byte, predicts every result and compares field by field
// depends on tga_pkg and tga_pixel_stream_decoder_unit

module tb_tga_pixel_stream_decoder_unit;
   import tga_pkg::*;

   typedef struct {
      logic [7:0] data_byte;
      logic       frame_start;
   } file_byte_type;

   localparam int QUIET_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_res;
   logic [2:0]  rsp_channels;
   logic [15:0] rsp_width, rsp_height;
   logic        rsp_last;

   file_byte_type file_bytes[$];
   result_type  decoded_results[$];
   int          fail_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic [7:0]  plan_code = 8'd10;

   // decoder shadow state
   logic [7:0]  rle_code = 8'd10;
   phase_type   phase = PH_HEADER;
   logic [4:0]  hdr_count = '0;
   logic [8:0]  skip_left = '0;
   logic        is_rle = 1'b0;
   logic [7:0]  depth = '0;
   logic [15:0] img_w = '0;
   logic [15:0] img_h = '0;
   logic [31:0] pix_left = '0;
   logic [7:0]  pkt_left = '0;
   logic        pkt_run = 1'b0;
   logic [1:0]  cidx = '0;
   logic [7:0]  cbytes [4];

   tga_pixel_stream_decoder_unit i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [2:0] out_channels();
      return (depth == DEPTH_32) ? 3'd4 : 3'd3;
   endfunction

   function automatic result_type bgr_pixel(input logic [7:0] rep);
      result_type r;
      r = '0;
      r.kind = KIND_PIXEL;
      r.red = cbytes[2];
      r.green = cbytes[1];
      r.blue = cbytes[0];
      r.alpha = (out_channels() == 3'd4) ? cbytes[3] : 8'd0;
      r.repeat_res = rep;
      r.channels = out_channels();
      r.width = img_w;
      r.height = img_h;
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic fs);
      result_type  r;
      logic        emit;
      logic        fmt_ok;
      logic [2:0]  need;
      logic [7:0]  rep;
      logic [15:0] w16;
      r = '0;
      emit = 1'b0;
      if (fs) begin
         phase = PH_HEADER;
         hdr_count = '0;
      end
      case (phase)
         PH_HEADER: begin
            case (hdr_count)
               5'd0:  skip_left = {1'b0, b} + 9'd1;
               5'd2:  is_rle = (b == rle_code);
               5'd12: img_w[7:0] = b;
               5'd13: img_w[15:8] = b;
               5'd14: img_h[7:0] = b;
               5'd15: img_h[15:8] = b;
               default: ;
            endcase
            if (hdr_count < HDR_DEPTH_IDX) begin
               hdr_count = hdr_count + 5'd1;
            end else begin
               depth = b;
               emit = 1'b1;
               r.width = img_w;
               r.height = img_h;
               fmt_ok = (b == DEPTH_24) || (b == DEPTH_32) || (!is_rle && b == DEPTH_16);
               if (!fmt_ok) begin
                  r.kind = KIND_ERROR;
                  r.last = 1'b1;
                  phase = PH_DONE;
               end else begin
                  pix_left = 32'(img_w) * 32'(img_h);
                  r.kind = KIND_HEADER;
                  r.channels = out_channels();
                  if (pix_left == 0) begin
                     r.last = 1'b1;
                     phase = PH_DONE;
                  end else begin
                     phase = PH_SKIP;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (skip_left > 0) skip_left = skip_left - 9'd1;
            if (skip_left == 0) begin
               phase = is_rle ? PH_PACKET : PH_RAW;
               cidx = '0;
            end
         end
         PH_RAW: begin
            need = (depth == DEPTH_16) ? 3'd2 : out_channels();
            cbytes[cidx] = b;
            if (3'(cidx) + 3'd1 < need) begin
               cidx = cidx + 2'd1;
            end else begin
               cidx = '0;
               emit = 1'b1;
               if (depth == DEPTH_16) begin
                  w16 = {cbytes[1], cbytes[0]};
                  r.kind = KIND_PIXEL;
                  r.red = {w16[14:10], 3'b000};
                  r.green = {w16[9:5], 3'b000};
                  r.blue = {w16[4:0], 3'b000};
                  r.repeat_res = 8'd1;
                  r.channels = 3'd3;
                  r.width = img_w;
                  r.height = img_h;
               end else begin
                  r = bgr_pixel(8'd1);
               end
               pix_left = pix_left - 1;
               if (pix_left == 0) begin
                  r.last = 1'b1;
                  phase = PH_DONE;
               end
            end
         end
         PH_PACKET: begin
            if (b < 8'd128) begin
               pkt_left = b + 8'd1;
               pkt_run = 1'b0;
            end else begin
               pkt_left = b - 8'd127;
               pkt_run = 1'b1;
            end
            cidx = '0;
            phase = PH_RLEPIX;
         end
         PH_RLEPIX: begin
            cbytes[cidx] = b;
            if (3'(cidx) + 3'd1 < out_channels()) begin
               cidx = cidx + 2'd1;
            end else begin
               cidx = '0;
               if (pkt_run) begin
                  rep = (32'(pkt_left) > pix_left) ? pix_left[7:0] : pkt_left;
                  pkt_left = '0;
               end else begin
                  rep = 8'd1;
                  pkt_left = pkt_left - 8'd1;
               end
               emit = 1'b1;
               r = bgr_pixel(rep);
               pix_left = pix_left - 32'(rep);
               if (pix_left == 0) begin
                  r.last = 1'b1;
                  phase = PH_DONE;
               end else if (pkt_left == 0) begin
                  phase = PH_PACKET;
               end
            end
         end
         default: ;
      endcase
      if (emit) decoded_results.push_back(r);
   endtask

   task automatic put_byte(input logic [7:0] b, input logic fs);
      file_byte_type fb;
      fb.data_byte = b;
      fb.frame_start = fs;
      file_bytes.push_back(fb);
   endtask

   // one tga file; cut limits the pixel data bytes (negative for none, but 40 above 4096 pixels)
   task automatic add_image(input logic [7:0] id_len, input logic rle, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] bits, input int cut);
      int npix;
      int bpp;
      int sent;
      int cnt;
      int k;
      logic run;
      npix = int'(w) * int'(h);
      bpp = (bits == DEPTH_16) ? 2 : ((bits == DEPTH_32) ? 4 : 3);
      sent = 0;
      put_byte(id_len, 1'b1);
      put_byte($urandom_range(255), 1'b0);
      put_byte(rle ? plan_code : 8'(int'(plan_code) + 1 + $urandom_range(254)), 1'b0);
      for (k = 3; k < 12; k++) put_byte($urandom_range(255), 1'b0);
      put_byte(w[7:0], 1'b0);
      put_byte(w[15:8], 1'b0);
      put_byte(h[7:0], 1'b0);
      put_byte(h[15:8], 1'b0);
      put_byte(bits, 1'b0);
      for (k = 0; k <= int'(id_len); k++) put_byte($urandom_range(255), 1'b0);
      if (cut < 0 && npix > 4096) cut = 40;
      if (!rle) begin
         for (k = 0; k < npix * bpp && (cut < 0 || k < cut); k++)
            put_byte($urandom_range(255), 1'b0);
      end else begin
         while (npix > 0 && (cut < 0 || sent < cut)) begin
            run = $urandom_range(1);
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 128)
                                           : $urandom_range(1, (npix < 6) ? npix + 1 : 6);
            put_byte(run ? 8'(cnt + 127) : 8'(cnt - 1), 1'b0);
            sent++;
            for (k = 0; k < (run ? 1 : cnt) * bpp; k++) put_byte($urandom_range(255), 1'b0);
            sent += (run ? 1 : cnt) * bpp;
            npix -= cnt;
         end
      end
      // trailing noise, ignored once the image is done
      for (k = $urandom_range(2); k > 0; k--) put_byte($urandom_range(255), 1'b0);
   endtask

   task automatic add_random_image();
      logic [7:0]  id_len;
      logic [7:0]  bits;
      logic [15:0] w, h;
      logic        rle;
      int          sel;
      id_len = ($urandom_range(40) == 0) ? 8'd255 : 8'($urandom_range(3));
      sel = $urandom_range(19);
      bits = (sel < 6) ? DEPTH_16 : (sel < 12) ? DEPTH_24 : (sel < 18) ? DEPTH_32
                                  : 8'($urandom_range(255));
      rle = (bits != DEPTH_16 || $urandom_range(9) == 0) ? $urandom_range(1) : 1'b0;
      w = ($urandom_range(30) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      h = ($urandom_range(30) == 0) ? 16'hffff : 16'($urandom_range(1, 4));
      add_image(id_len, rle, w, h, bits, ($urandom_range(9) == 0) ? $urandom_range(12) : -1);
   endtask

   task automatic wait_idle();
      while (file_bytes.size() != 0 || req_valid || decoded_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_rle_code(input logic [7:0] code);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      csr_we <= 1'b0;
      plan_code = code;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (csr_we) rle_code = csr_wdata;
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_frame_start);
         if (!req_valid || !req_stall) begin
            if (file_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data_byte <= file_bytes[0].data_byte;
               req_frame_start <= file_bytes[0].frame_start;
               void'(file_bytes.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_results.size() == 0) begin
               $error("unexpected result transfer, kind %0d", rsp_result_kind);
               fail_count++;
            end else begin
               e = decoded_results.pop_front();
               if (rsp_result_kind != e.kind) begin
                  $error("result_kind: expected %0d, got %0d", e.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_red != e.red) begin
                  $error("red: expected %0d, got %0d", e.red, rsp_red);
                  fail_count++;
               end
               if (rsp_green != e.green) begin
                  $error("green: expected %0d, got %0d", e.green, rsp_green);
                  fail_count++;
               end
               if (rsp_blue != e.blue) begin
                  $error("blue: expected %0d, got %0d", e.blue, rsp_blue);
                  fail_count++;
               end
               if (rsp_alpha != e.alpha) begin
                  $error("alpha: expected %0d, got %0d", e.alpha, rsp_alpha);
                  fail_count++;
               end
               if (rsp_repeat_res != e.repeat_res) begin
                  $error("repeat_res: expected %0d, got %0d", e.repeat_res, rsp_repeat_res);
                  fail_count++;
               end
               if (rsp_channels != e.channels) begin
                  $error("channels: expected %0d, got %0d", e.channels, rsp_channels);
                  fail_count++;
               end
               if (rsp_width != e.width) begin
                  $error("width: expected %0d, got %0d", e.width, rsp_width);
                  fail_count++;
               end
               if (rsp_height != e.height) begin
                  $error("height: expected %0d, got %0d", e.height, rsp_height);
                  fail_count++;
               end
               if (rsp_last != e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int p;
      logic [7:0] codes [5];
      codes = '{8'd10, 8'd0, 8'd255, 8'd2, 8'($urandom_range(255))};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < 5; p++) begin
         wait_idle();
         write_rle_code(codes[p]);
         idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 34 : 62) : 0;
         stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 34 : 62) : 0;
         if (p == 0) begin
            // directed: each format, clipping, errors, empty and oversized images
            add_image(8'd0, 1'b0, 16'd1, 16'd2, DEPTH_16, -1);
            add_image(8'd1, 1'b0, 16'd1, 16'd1, DEPTH_24, -1);
            add_image(8'd0, 1'b0, 16'd1, 16'd1, DEPTH_32, -1);
            add_image(8'd0, 1'b1, 16'd2, 16'd1, DEPTH_24, -1);
            add_image(8'd0, 1'b1, 16'd1, 16'd3, DEPTH_32, -1);
            add_image(8'd0, 1'b0, 16'd1, 16'd1, 8'd8, -1);
            add_image(8'd0, 1'b1, 16'd1, 16'd1, DEPTH_16, -1);
            add_image(8'd0, 1'b0, 16'd0, 16'd5, DEPTH_24, -1);
            add_image(8'd255, 1'b0, 16'hffff, 16'hffff, DEPTH_32, 8);
            // long receiver hold so the result queue fills and the input stalls
            hold_request = 400;
         end
         while (file_bytes.size() < 350) add_random_image();
      end
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && decoded_results.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
